// File: rtl/vtpv_pkg.sv
// Shared constants, register codes and control struct for the vertex transform pipeline.
package vtpv_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 12;
  localparam int VIEW_DIST   = 3;
  localparam int COEF_W      = 16;
  localparam int OUT_W       = 16;
  localparam int GAIN_W      = 24;
  localparam int GAIN_FRAC   = 8;
  localparam int ROW_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_Z,
    REG_XMIN,
    REG_YMIN,
    REG_XGAIN,
    REG_YGAIN
  } cfg_idx_t;

  localparam logic [ROW_W-1:0]  ROW_X_RST = 64'h0004_0000_0000_0000;
  localparam logic [ROW_W-1:0]  ROW_Y_RST = 64'h0000_0010_0000_0000;
  localparam logic [ROW_W-1:0]  ROW_Z_RST = 64'h0000_0000_1000_0000;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 24'd256;

  typedef struct packed {
    logic valid;
    logic behind;
    logic sat;
  } ctl_t;

endpackage

// File: rtl/vtpv_xform.sv
// Matrix transform (products, rounded sum, clip) and projection operand setup.
module vtpv_xform #(
  parameter int W = vtpv_pkg::COORD_WIDTH,
  parameter int F = vtpv_pkg::FRAC_BITS,
  localparam int DEN_W = ((W > F + 2) ? W : F + 2) + 1,
  localparam int MAG_W = W + F + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [W-1:0]           vx,
  input  logic signed [W-1:0]           vy,
  input  logic signed [W-1:0]           vz,
  input  logic [vtpv_pkg::ROW_W-1:0]    row_x,
  input  logic [vtpv_pkg::ROW_W-1:0]    row_y,
  input  logic [vtpv_pkg::ROW_W-1:0]    row_z,
  output vtpv_pkg::ctl_t                ctl,
  output logic [DEN_W-1:0]              den,
  output logic [MAG_W-1:0]              mag_x,
  output logic                          neg_x,
  output logic [MAG_W-1:0]              mag_y,
  output logic                          neg_y
);

  localparam int PW = vtpv_pkg::COEF_W + W;
  localparam int TW = vtpv_pkg::COEF_W + F;
  localparam int AW = ((PW > TW) ? PW : TW) + 3;
  localparam logic signed [AW-1:0] RND = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [AW-1:0] HI  = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] LO  = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [DEN_W-1:0] VD =
    DEN_W'(longint'(vtpv_pkg::VIEW_DIST) <<< F);

  logic [vtpv_pkg::ROW_W-1:0] rows [3];
  logic signed [W-1:0]        vin  [3];

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;
  assign vin[0]  = vx;
  assign vin[1]  = vy;
  assign vin[2]  = vz;

  // stage 1: products
  logic signed [PW-1:0] p1 [3][3];
  logic signed [TW-1:0] t1 [3];
  vtpv_pkg::ctl_t       c1;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1[r][c] <= $signed(rows[r][63-16*c -: 16]) * vin[c];
        end
        t1[r] <= {rows[r][15:0], {F{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else if (adv) begin
      c1.valid  <= in_valid;
      c1.behind <= 1'b0;
      c1.sat    <= 1'b0;
    end
  end

  // stage 2: sum, round half up, clip
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] sh  [3];
  logic signed [W-1:0]  tc  [3];
  logic [2:0]           tsat;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(p1[r][0]) + AW'(p1[r][1]) + AW'(p1[r][2]) + AW'(t1[r]) + RND;
      sh[r]  = acc[r] >>> F;
      tsat[r] = 1'b0;
      if (sh[r] > HI) begin
        tc[r] = HI[W-1:0];
        tsat[r] = 1'b1;
      end else if (sh[r] < LO) begin
        tc[r] = LO[W-1:0];
        tsat[r] = 1'b1;
      end else begin
        tc[r] = sh[r][W-1:0];
      end
    end
  end

  logic signed [W-1:0] t2 [3];
  vtpv_pkg::ctl_t      c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) t2[r] <= tc[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
    end else if (adv) begin
      c2.valid  <= c1.valid;
      c2.behind <= 1'b0;
      c2.sat    <= |tsat;
    end
  end

  // stage 3: denominator, numerator magnitudes and signs
  logic signed [DEN_W-1:0] den_c;
  logic signed [W+1:0]     nx3, ny3, ax3, ay3;

  always_comb begin
    den_c = DEN_W'(t2[2]) + VD;
    nx3   = (W+2)'(t2[0]) * (W+2)'(vtpv_pkg::VIEW_DIST);
    ny3   = (W+2)'(t2[1]) * (W+2)'(vtpv_pkg::VIEW_DIST);
    ax3   = nx3[W+1] ? -nx3 : nx3;
    ay3   = ny3[W+1] ? -ny3 : ny3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den   <= den_c;
      mag_x <= {ax3[W:0], {F{1'b0}}};
      mag_y <= {ay3[W:0], {F{1'b0}}};
      neg_x <= t2[0][W-1];
      // y is negated after the divide
      neg_y <= ~t2[1][W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl.valid  <= c2.valid;
      ctl.behind <= den_c[DEN_W-1] | (den_c == '0);
      ctl.sat    <= c2.sat;
    end
  end

endmodule

// File: rtl/vtpv_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
module vtpv_div #(
  parameter int DEN_W = 18,
  parameter int MAG_W = 29
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [DEN_W-1:0] den,
  input  logic [MAG_W-1:0] num,
  output logic [MAG_W-1:0] quo
);

  logic [DEN_W-1:0] rem [1:MAG_W-1];
  logic [MAG_W-1:0] qq  [1:MAG_W];
  logic [DEN_W-1:0] dd  [1:MAG_W-1];
  logic [MAG_W-1:0] nm  [1:MAG_W-1];

  for (genvar j = 0; j < MAG_W; j++) begin : g_st
    logic [DEN_W-1:0] r_in, d_in, trial;
    logic [MAG_W-1:0] n_in, q_in;
    logic             ge;

    if (j == 0) begin : g_first
      assign r_in = '0;
      assign d_in = den;
      assign n_in = num;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[j];
      assign d_in = dd[j];
      assign n_in = nm[j];
      assign q_in = qq[j];
    end

    // remainder stays below den, so the shifted value fits DEN_W bits
    assign trial = {r_in[DEN_W-2:0], n_in[MAG_W-1-j]};
    assign ge    = trial >= d_in;

    always_ff @(posedge clk) begin
      if (adv) begin
        qq[j+1]  <= {q_in[MAG_W-2:0], ge};
      end
    end

    if (j < MAG_W - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[j+1] <= ge ? trial - d_in : trial;
          dd[j+1]  <= d_in;
          nm[j+1]  <= n_in;
        end
      end
    end
  end

  assign quo = qq[MAG_W];

endmodule

// File: rtl/vtpv_view.sv
// Projection clip, viewport offset and gain, screen clip.
module vtpv_view #(
  parameter int W = vtpv_pkg::COORD_WIDTH,
  parameter int F = vtpv_pkg::FRAC_BITS,
  localparam int MAG_W = W + F + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  vtpv_pkg::ctl_t                    ctl_in,
  input  logic [MAG_W-1:0]                  mag_x,
  input  logic                              neg_x,
  input  logic [MAG_W-1:0]                  mag_y,
  input  logic                              neg_y,
  input  logic signed [vtpv_pkg::OUT_W-1:0] xmin,
  input  logic signed [vtpv_pkg::OUT_W-1:0] ymin,
  input  logic [vtpv_pkg::GAIN_W-1:0]       xgain,
  input  logic [vtpv_pkg::GAIN_W-1:0]       ygain,
  output vtpv_pkg::ctl_t                    ctl_out,
  output logic signed [vtpv_pkg::OUT_W-1:0] screen_x,
  output logic signed [vtpv_pkg::OUT_W-1:0] screen_y
);

  localparam int OW  = vtpv_pkg::OUT_W;
  localparam int QW  = MAG_W + 1;
  localparam int DW  = ((W > OW) ? W : OW) + 1;
  localparam int PRW = DW + vtpv_pkg::GAIN_W + 1;
  localparam int SH  = F + vtpv_pkg::GAIN_FRAC;
  localparam logic signed [QW-1:0]  QHI = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [QW-1:0]  QLO = {{(QW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [PRW-1:0] SHI = {{(PRW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [PRW-1:0] SLO = {{(PRW-OW+1){1'b1}}, {(OW-1){1'b0}}};

  logic [MAG_W-1:0]          mag  [2];
  logic                      neg  [2];
  logic signed [OW-1:0]      amin [2];
  logic [vtpv_pkg::GAIN_W-1:0] gain [2];

  assign mag[0]  = mag_x;
  assign mag[1]  = mag_y;
  assign neg[0]  = neg_x;
  assign neg[1]  = neg_y;
  assign amin[0] = xmin;
  assign amin[1] = ymin;
  assign gain[0] = xgain;
  assign gain[1] = ygain;

  // stage a: signed quotient, clip, subtract axis minimum
  logic signed [QW-1:0] sq [2];
  logic signed [W-1:0]  pc [2];
  logic [1:0]           psat;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sq[a] = neg[a] ? -$signed({1'b0, mag[a]}) : $signed({1'b0, mag[a]});
      psat[a] = 1'b0;
      if (sq[a] > QHI) begin
        pc[a] = QHI[W-1:0];
        psat[a] = 1'b1;
      end else if (sq[a] < QLO) begin
        pc[a] = QLO[W-1:0];
        psat[a] = 1'b1;
      end else begin
        pc[a] = sq[a][W-1:0];
      end
    end
  end

  logic signed [DW-1:0] diff [2];
  vtpv_pkg::ctl_t       ca;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 2; a++) diff[a] <= DW'(pc[a]) - DW'(amin[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ca <= '0;
    end else if (adv) begin
      ca.valid  <= ctl_in.valid;
      ca.behind <= ctl_in.behind;
      ca.sat    <= ctl_in.sat | (~ctl_in.behind & (|psat));
    end
  end

  // stage b: gain
  logic signed [PRW-1:0] prod [2];
  vtpv_pkg::ctl_t        cb;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 2; a++) prod[a] <= diff[a] * $signed({1'b0, gain[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cb <= '0;
    end else if (adv) begin
      cb <= ca;
    end
  end

  // stage c: floor shift, clip to screen range
  logic signed [PRW-1:0] ps [2];
  logic signed [OW-1:0]  sc [2];
  logic [1:0]            ssat;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ps[a] = prod[a] >>> SH;
      ssat[a] = 1'b0;
      if (ps[a] > SHI) begin
        sc[a] = SHI[OW-1:0];
        ssat[a] = 1'b1;
      end else if (ps[a] < SLO) begin
        sc[a] = SLO[OW-1:0];
        ssat[a] = 1'b1;
      end else begin
        sc[a] = ps[a][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      screen_x <= cb.behind ? '0 : sc[0];
      screen_y <= cb.behind ? '0 : sc[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out.valid  <= cb.valid;
      ctl_out.behind <= cb.behind;
      ctl_out.sat    <= cb.sat | (~cb.behind & (|ssat));
    end
  end

endmodule

// File: rtl/vertex_transform_project_viewport_core.sv
// Top level: config registers, transform, divider pipelines and viewport stages.
//
// Vertices arrive on the s_axis stream, one beat per vertex (x, y, z in tdata),
// and leave on the m_axis stream, one beat per vertex: screen x and y in tdata,
// behind_viewer and saturated in tuser. Config registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no vertex is
// in flight, as the core does not enforce this. The pipeline has three
// transform stages, one divider stage per quotient bit and three viewport
// stages. Throughput is one vertex per cycle unless the receiver stalls; every
// stage is registered and the two dividers (x and y) are fully pipelined.
// The whole pipeline advances whenever the output register is empty or its beat
// is taken; when the receiver stalls, all stages hold and s_axis_tready drops,
// so nothing is lost or repeated. Beats already in the pipeline keep their
// place. Reset clears all valid bits and loads the default matrix rows,
// zero axis minima and unit gains.
module vertex_transform_project_viewport_core #(
  parameter int COORD_WIDTH = vtpv_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = vtpv_pkg::FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [vtpv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vtpv_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // vertex_x, vertex_y, vertex_z, zero pad
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // screen_x, screen_y
  output logic [2*vtpv_pkg::OUT_W-1:0]           m_axis_tdata,
  // behind_viewer, saturated
  output logic [1:0]                             m_axis_tuser
);

  localparam int W     = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DEN_W = ((W > F + 2) ? W : F + 2) + 1;
  localparam int MAG_W = W + F + 1;

  logic [vtpv_pkg::ROW_W-1:0]        row_x, row_y, row_z;
  logic signed [vtpv_pkg::OUT_W-1:0] xmin, ymin;
  logic [vtpv_pkg::GAIN_W-1:0]       xgain, ygain;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= vtpv_pkg::ROW_X_RST;
      row_y <= vtpv_pkg::ROW_Y_RST;
      row_z <= vtpv_pkg::ROW_Z_RST;
      xmin  <= '0;
      ymin  <= '0;
      xgain <= vtpv_pkg::GAIN_RST;
      ygain <= vtpv_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (vtpv_pkg::cfg_idx_t'(cfg_index))
        vtpv_pkg::REG_ROW_X: row_x <= cfg_data;
        vtpv_pkg::REG_ROW_Y: row_y <= cfg_data;
        vtpv_pkg::REG_ROW_Z: row_z <= cfg_data;
        vtpv_pkg::REG_XMIN:  xmin  <= cfg_data[vtpv_pkg::OUT_W-1:0];
        vtpv_pkg::REG_YMIN:  ymin  <= cfg_data[vtpv_pkg::OUT_W-1:0];
        vtpv_pkg::REG_XGAIN: xgain <= cfg_data[vtpv_pkg::GAIN_W-1:0];
        vtpv_pkg::REG_YGAIN: ygain <= cfg_data[vtpv_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  vtpv_pkg::ctl_t ctl_out;
  logic           adv;

  assign adv           = ~ctl_out.valid | m_axis_tready;
  assign s_axis_tready = adv;

  vtpv_pkg::ctl_t   xf_ctl;
  logic [DEN_W-1:0] den;
  logic [MAG_W-1:0] mag_x, mag_y, quo_x, quo_y;
  logic             neg_x, neg_y;

  vtpv_xform #(.W(W), .F(F)) u_xform (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_axis_tvalid),
    .vx       ($signed(s_axis_tdata[W-1:0])),
    .vy       ($signed(s_axis_tdata[2*W-1:W])),
    .vz       ($signed(s_axis_tdata[3*W-1:2*W])),
    .row_x    (row_x),
    .row_y    (row_y),
    .row_z    (row_z),
    .ctl      (xf_ctl),
    .den      (den),
    .mag_x    (mag_x),
    .neg_x    (neg_x),
    .mag_y    (mag_y),
    .neg_y    (neg_y)
  );

  vtpv_div #(.DEN_W(DEN_W), .MAG_W(MAG_W)) u_div_x (
    .clk (clk),
    .adv (adv),
    .den (den),
    .num (mag_x),
    .quo (quo_x)
  );

  vtpv_div #(.DEN_W(DEN_W), .MAG_W(MAG_W)) u_div_y (
    .clk (clk),
    .adv (adv),
    .den (den),
    .num (mag_y),
    .quo (quo_y)
  );

  // control and signs ride alongside the divider stages
  vtpv_pkg::ctl_t dctl [1:MAG_W];
  logic           dnx  [1:MAG_W];
  logic           dny  [1:MAG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= MAG_W; j++) dctl[j] <= '0;
    end else if (adv) begin
      dctl[1] <= xf_ctl;
      for (int j = 2; j <= MAG_W; j++) dctl[j] <= dctl[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dnx[1] <= neg_x;
      dny[1] <= neg_y;
      for (int j = 2; j <= MAG_W; j++) begin
        dnx[j] <= dnx[j-1];
        dny[j] <= dny[j-1];
      end
    end
  end

  logic signed [vtpv_pkg::OUT_W-1:0] screen_x, screen_y;

  vtpv_view #(.W(W), .F(F)) u_view (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .ctl_in   (dctl[MAG_W]),
    .mag_x    (quo_x),
    .neg_x    (dnx[MAG_W]),
    .mag_y    (quo_y),
    .neg_y    (dny[MAG_W]),
    .xmin     (xmin),
    .ymin     (ymin),
    .xgain    (xgain),
    .ygain    (ygain),
    .ctl_out  (ctl_out),
    .screen_x (screen_x),
    .screen_y (screen_y)
  );

  assign m_axis_tvalid = ctl_out.valid;
  assign m_axis_tdata  = {screen_y, screen_x};
  assign m_axis_tuser  = {ctl_out.sat, ctl_out.behind};

endmodule

// File: tb/tb.sv
// Testbench for the vertex transform, projection and viewport core: random and directed vertices, scoreboard check.
module tb;

  localparam int LAT = vtpv_pkg::COORD_WIDTH + vtpv_pkg::FRAC_BITS + 7;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic        behind;
    logic        sat;
  } pixel_t;

  // Predicts screen results and holds them in order of arrival.
  class pixel_scoreboard;
    logic [63:0] rows[3];
    logic signed [15:0] xmin, ymin;
    logic [23:0] xgain, ygain;
    pixel_t pending[$];
    int errors;
    int checked;

    function void reset_regs();
      rows[0] = vtpv_pkg::ROW_X_RST;
      rows[1] = vtpv_pkg::ROW_Y_RST;
      rows[2] = vtpv_pkg::ROW_Z_RST;
      xmin = '0;
      ymin = '0;
      xgain = vtpv_pkg::GAIN_RST;
      ygain = vtpv_pkg::GAIN_RST;
    endfunction

    function void write_reg(vtpv_pkg::cfg_idx_t idx, logic [63:0] val);
      case (idx)
        vtpv_pkg::REG_ROW_X: rows[0] = val;
        vtpv_pkg::REG_ROW_Y: rows[1] = val;
        vtpv_pkg::REG_ROW_Z: rows[2] = val;
        vtpv_pkg::REG_XMIN: xmin = val[15:0];
        vtpv_pkg::REG_YMIN: ymin = val[15:0];
        vtpv_pkg::REG_XGAIN: xgain = val[23:0];
        vtpv_pkg::REG_YGAIN: ygain = val[23:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, int w, inout bit sat);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        sat = 1;
        return hi;
      end
      if (v < lo) begin
        sat = 1;
        return lo;
      end
      return v;
    endfunction

    function longint transform(logic [63:0] row, longint v[3], inout bit sat);
      longint acc;
      acc = 0;
      for (int c = 0; c < 3; c++)
        acc += longint'($signed(row[63-16*c -: 16])) * v[c];
      acc += longint'($signed(row[15:0])) <<< vtpv_pkg::FRAC_BITS;
      acc += longint'(1) <<< (vtpv_pkg::FRAC_BITS - 1);
      return clamp(acc >>> vtpv_pkg::FRAC_BITS, vtpv_pkg::COORD_WIDTH, sat);
    endfunction

    function longint viewport(longint p, longint mn, logic [23:0] g, inout bit sat);
      longint prod;
      prod = (p - mn) * longint'({1'b0, g});
      return clamp(prod >>> (vtpv_pkg::FRAC_BITS + 8), 16, sat);
    endfunction

    function void note_vertex(logic signed [15:0] vx, vy, vz);
      longint v[3];
      longint tx, ty, tz, den, px, py, sx, sy;
      bit sat;
      pixel_t e;
      sat = 0;
      sx = 0;
      sy = 0;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      tx = transform(rows[0], v, sat);
      ty = transform(rows[1], v, sat);
      tz = transform(rows[2], v, sat);
      den = tz + (longint'(vtpv_pkg::VIEW_DIST) <<< vtpv_pkg::FRAC_BITS);
      if (den > 0) begin
        // SV division truncates toward zero like the hardware divider
        px = (tx * vtpv_pkg::VIEW_DIST * (longint'(1) <<< vtpv_pkg::FRAC_BITS)) / den;
        py = -((ty * vtpv_pkg::VIEW_DIST * (longint'(1) <<< vtpv_pkg::FRAC_BITS)) / den);
        px = clamp(px, vtpv_pkg::COORD_WIDTH, sat);
        py = clamp(py, vtpv_pkg::COORD_WIDTH, sat);
        sx = viewport(px, xmin, xgain, sat);
        sy = viewport(py, ymin, ygain, sat);
      end
      e.sx = sx[15:0];
      e.sy = sy[15:0];
      e.behind = den <= 0;
      e.sat = sat;
      pending.push_back(e);
    endfunction

    function void check_pixel(logic [31:0] data, logic [1:0] user);
      pixel_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat data=%h user=%b", $time, data, user);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.sx) begin
        $display("%0t: screen_x exp %h got %h", $time, e.sx, data[15:0]);
        errors++;
      end
      if (data[31:16] !== e.sy) begin
        $display("%0t: screen_y exp %h got %h", $time, e.sy, data[31:16]);
        errors++;
      end
      if (user[0] !== e.behind) begin
        $display("%0t: behind_viewer exp %b got %b", $time, e.behind, user[0]);
        errors++;
      end
      if (user[1] !== e.sat) begin
        $display("%0t: saturated exp %b got %b", $time, e.sat, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [vtpv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vtpv_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  int src_idle = 0, sink_idle = 0;
  bit sink_hold = 0;
  int cycles = 0;
  int sent = 0;
  pixel_scoreboard sb;

  vertex_transform_project_viewport_core u_dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sample results at the rising edge
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_pixel(m_axis_tdata, m_axis_tuser);

  always @(negedge clk)
    m_axis_tready <= !rst && !sink_hold && ($urandom_range(99) >= sink_idle);

  task automatic write_cfg(vtpv_pkg::cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // leaves tvalid high on return; the next send or drain sets it
  task automatic send_vertex(logic [15:0] vx, vy, vz);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {vz, vy, vx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_vertex(vx, vy, vz);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_row();
    logic [63:0] r;
    for (int c = 0; c < 4; c++)
      r[c*16 +: 16] = $urandom_range(3) == 0 ? 16'($urandom)
                                             : 16'($urandom_range(8191) - 4096);
    return r;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic random_config();
    write_cfg(vtpv_pkg::REG_ROW_X, rand_row());
    write_cfg(vtpv_pkg::REG_ROW_Y, rand_row());
    write_cfg(vtpv_pkg::REG_ROW_Z, rand_row());
    write_cfg(vtpv_pkg::REG_XMIN, {$urandom, $urandom});
    write_cfg(vtpv_pkg::REG_YMIN, {$urandom, $urandom});
    write_cfg(vtpv_pkg::REG_XGAIN, $urandom_range(2) == 0 ? {$urandom, $urandom}
                                                          : 64'($urandom_range(4096)));
    write_cfg(vtpv_pkg::REG_YGAIN, $urandom_range(2) == 0 ? {$urandom, $urandom}
                                                          : 64'($urandom_range(4096)));
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset matrix, extremes, behind viewer, zero and huge gains
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h1000, 16'hf000, 16'hd000);  // z = -3: den zero
    send_vertex(16'h1000, 16'h1000, 16'hc000);  // behind
    send_vertex(16'h7fff, 16'h8000, 16'hd001);  // tiny den, projection clips
    send_vertex(16'h8000, 16'h7fff, 16'h0001);
    drain();
    write_cfg(vtpv_pkg::REG_XGAIN, 64'hffffff);
    write_cfg(vtpv_pkg::REG_YGAIN, 64'h0);
    write_cfg(vtpv_pkg::REG_XMIN, 64'h8000);
    write_cfg(vtpv_pkg::REG_YMIN, 64'h7fff);
    write_cfg(vtpv_pkg::REG_ROW_X, 64'h7fff_7fff_7fff_7fff);
    write_cfg(vtpv_pkg::REG_ROW_Y, 64'h8000_8000_8000_8000);
    write_cfg(vtpv_pkg::REG_ROW_Z, 64'h0000_0000_0000_8000);  // tz at its lowest value: behind
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    drain();
    write_cfg(vtpv_pkg::REG_ROW_Z, 64'hffff_ffff_ffff_7fff);
    send_vertex(16'h5555, 16'haaaa, 16'h0123);
    send_vertex(16'haaaa, 16'h5555, 16'hfedc);
    drain();

    src_idle = 37;
    sink_idle = 69;
    random_config();
    random_phase(200);

    // long receiver stall while the sender keeps pushing
    fork
      begin
        sink_hold = 1;
        repeat (300) @(negedge clk);
        sink_hold = 0;
      end
      random_phase(60);
    join
    drain();  // sender waits for all results

    src_idle = 69;
    sink_idle = 37;
    random_config();
    random_phase(200);
    drain();

    src_idle = 0;
    sink_idle = 0;
    write_cfg(vtpv_pkg::REG_ROW_X, 64'h1000_0000_0000_0000);
    write_cfg(vtpv_pkg::REG_ROW_Y, 64'h0000_1000_0000_0000);
    write_cfg(vtpv_pkg::REG_ROW_Z, 64'h0000_0000_1000_0000);
    write_cfg(vtpv_pkg::REG_XMIN, 64'hc000);
    write_cfg(vtpv_pkg::REG_YMIN, 64'hc000);
    write_cfg(vtpv_pkg::REG_XGAIN, 64'd20480);
    write_cfg(vtpv_pkg::REG_YGAIN, 64'd15360);
    random_phase(150);
    drain();
    random_config();
    random_phase(150);
    drain();

    $display("Sent %0d vertices over several matrix, offset and gain settings;", sent);
    $display("checked %0d screen beats under sender and receiver stalls.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

// File: files.f
rtl/vtpv_pkg.sv
rtl/vtpv_xform.sv
rtl/vtpv_div.sv
rtl/vtpv_view.sv
rtl/vertex_transform_project_viewport_core.sv
tb/tb.sv
